### rtl/core/assert_macros.svh
// Assertion macros shared by the polygon clear pair counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pcpc_pkg.sv
// Package with the types, codes and defaults of the polygon clear pair counter.
package pcpc_pkg;

    // Default sizes of the stores and of the coordinates.
    localparam int DEF_MAX_VERTICES = 256;
    localparam int DEF_MAX_POINTS   = 256;
    localparam int DEF_COORD_BITS   = 21;

    // Width and saturation value of the pair count.
    localparam int COUNT_W = 15;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    // Item commands.
    typedef enum logic [1:0] {
        CMD_CLEAR       = 2'd0,
        CMD_LOAD_VERTEX = 2'd1,
        CMD_LOAD_POINT  = 2'd2,
        CMD_COMPUTE     = 2'd3
    } t_cmd;

    // Orientation of an ordered point triple.
    typedef enum logic [1:0] {
        ORIENT_COLL = 2'd0,
        ORIENT_CW   = 2'd1,
        ORIENT_CCW  = 2'd2
    } t_orient;

    // Micro-steps of one segment test: eight orientation products, then
    // eight bounding box products.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step STEP_BOX_FIRST = 4'd8;
    localparam t_step STEP_LAST      = 4'd15;

    // Control that travels alongside an operand set through the product unit.
    typedef struct packed {
        logic  vld;
        t_step tag;
    } t_prod_ctl;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NEXT_I,
        ST_LOAD_I,
        ST_NEXT_J,
        ST_LOAD_J,
        ST_EDGE,
        ST_LOAD_VA,
        ST_LOAD_VB,
        ST_ISSUE,
        ST_DRAIN,
        ST_EVAL,
        ST_COUNT,
        ST_DONE
    } t_state;

endpackage

### rtl/core/pcpc_if.sv
// Valid/ready channel interfaces for command items and count results.
interface pcpc_in_if
    import pcpc_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (output valid, command, coord_x, coord_y, input ready);
    modport sink   (input valid, command, coord_x, coord_y, output ready);
endinterface

interface pcpc_out_if
    import pcpc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] pair_count;

    modport source (output valid, pair_count, input ready);
    modport sink   (input valid, pair_count, output ready);
endinterface

### rtl/core/pcpc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pcpc_ram
    import pcpc_pkg::*;
#(
    parameter int WIDTH = 2 * DEF_COORD_BITS,
    parameter int DEPTH = DEF_MAX_POINTS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pcpc_prod_unit.sv
// Shared two-stage unit that forms the product (a - b) * (c - d).
module pcpc_prod_unit
    import pcpc_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    localparam int DIFF_W    = COORD_BITS + 1,
    localparam int PROD_W    = 2 * DIFF_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_prod_ctl                    i_ctl,
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    input  logic signed [COORD_BITS-1:0] i_c,
    input  logic signed [COORD_BITS-1:0] i_d,
    output t_prod_ctl                    o_ctl,
    output logic signed [PROD_W-1:0]     o_prod,
    output logic                         o_busy
);

    t_prod_ctl                r_ctl_diff;
    t_prod_ctl                r_ctl_prod;
    logic signed [DIFF_W-1:0] r_da;
    logic signed [DIFF_W-1:0] r_db;
    logic signed [PROD_W-1:0] r_prod;

    // Control tags follow the operands down the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_diff <= '0;
            r_ctl_prod <= '0;
        end else begin
            r_ctl_diff <= i_ctl;
            r_ctl_prod <= r_ctl_diff;
        end
    end

    // First stage: the two differences, exact in one extra bit.
    always_ff @(posedge i_clk) begin
        r_da <= DIFF_W'(i_a) - DIFF_W'(i_b);
        r_db <= DIFF_W'(i_c) - DIFF_W'(i_d);
    end

    // Second stage: the signed product.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_da) * PROD_W'(r_db);
    end

    assign o_ctl  = r_ctl_prod;
    assign o_prod = r_prod;
    assign o_busy = r_ctl_diff.vld | r_ctl_prod.vld;

endmodule

### rtl/core/polygon_clear_pair_counter_unit.sv
// Top level of the polygon clear pair counter: stores, sequencer and segment test.
//
// Usage. Items arrive on i_in (valid/ready) and carry a command with one point.
// Clear empties both stores, load vertex and load point append the point to the
// polygon or to the point set (loads beyond capacity are dropped), and compute
// returns one result item on o_out: the number of unordered point pairs whose
// segment touches no polygon edge, saturating at 32767.
// Clear and load items keep i_in.ready high and give no result.
// A compute item keeps i_in.ready low until its count is in the output
// register. The edge walk of a pair stops at the first touching edge. The
// edge test runs on one shared subtract-multiply unit that forms sixteen
// products per edge, and each point or vertex is fetched through the single
// read port of its store.
// Reset empties both stores and drops a pending result; no clearing pass runs.
// The result waits in an output register while the receiver stalls, and load
// items are still taken meanwhile; a compute that finishes before the earlier
// result is taken waits for it.
`include "assert_macros.svh"

module polygon_clear_pair_counter_unit
    import pcpc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcpc_in_if.sink    i_in,
    pcpc_out_if.source o_out
);

    localparam int VA_W   = $clog2(MAX_VERTICES);
    localparam int VT_CW  = $clog2(MAX_VERTICES + 1);
    localparam int PA_W   = $clog2(MAX_POINTS);
    localparam int PT_CW  = $clog2(MAX_POINTS + 1);
    localparam int DATA_W = 2 * COORD_BITS;
    localparam int PROD_W = 2 * (COORD_BITS + 1);

    // Sequencer and counters.
    t_state             r_state, n_state;
    logic [VT_CW-1:0]   r_vt_total, n_vt_total;
    logic [PT_CW-1:0]   r_pt_total, n_pt_total;
    logic [PT_CW-1:0]   r_i, n_i;
    logic [PT_CW-1:0]   r_j, n_j;
    logic [VT_CW-1:0]   r_k, n_k;
    t_step              r_step, n_step;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_out_vld, n_out_vld;
    logic [COUNT_W-1:0] r_out_cnt, n_out_cnt;

    // Segment end points under test: P, Q from the point set, V, W from the polygon.
    logic signed [COORD_BITS-1:0] r_p_x, r_p_y, r_q_x, r_q_y;
    logic signed [COORD_BITS-1:0] r_v_x, r_v_y, r_w_x, r_w_y;

    // Partial results of the segment test.
    logic signed [PROD_W-1:0] r_lhs;
    t_orient                  r_orient [4];
    logic [7:0]               r_box;

    // Store ports.
    logic              v_we, v_re, p_we, p_re;
    logic [VA_W-1:0]   v_raddr;
    logic [PA_W-1:0]   p_raddr;
    logic [DATA_W-1:0] v_rdata, p_rdata, in_wdata;

    // Product unit ports.
    t_prod_ctl                    u_in_ctl, u_out_ctl;
    logic signed [COORD_BITS-1:0] op_a, op_b, op_c, op_d;
    logic signed [PROD_W-1:0]     u_prod;
    logic                         u_busy;

    logic             in_acc;
    logic [VT_CW-1:0] k_inc;
    logic [VT_CW-1:0] k_next_edge;
    t_orient          orient_new;
    logic             touch;

    assign in_acc   = i_in.valid & i_in.ready;
    assign in_wdata = {i_in.coord_x, i_in.coord_y};
    assign k_inc    = r_k + VT_CW'(1);
    // The last edge closes the polygon back to vertex zero.
    assign k_next_edge = (k_inc < r_vt_total) ? k_inc : '0;

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_vld;
    assign o_out.pair_count = r_out_cnt;

    pcpc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (r_vt_total[VA_W-1:0]),
        .i_wdata (in_wdata),
        .i_re    (v_re),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    pcpc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_pt_total[PA_W-1:0]),
        .i_wdata (in_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    pcpc_prod_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_prod_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (u_in_ctl),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_c     (op_c),
        .i_d     (op_d),
        .o_ctl   (u_out_ctl),
        .o_prod  (u_prod),
        .o_busy  (u_busy)
    );

    // Operand selection per micro-step. Orientation products come in pairs
    // (left then right side of the cross product compare); bounding box
    // products are (q - a) * (q - c), which is not positive exactly when q
    // lies between a and c on that axis.
    always_comb begin
        op_a = r_q_y; op_b = r_p_y; op_c = r_v_x; op_d = r_q_x;
        case (r_step)
            4'd0:  begin op_a = r_q_y; op_b = r_p_y; op_c = r_v_x; op_d = r_q_x; end
            4'd1:  begin op_a = r_q_x; op_b = r_p_x; op_c = r_v_y; op_d = r_q_y; end
            4'd2:  begin op_a = r_q_y; op_b = r_p_y; op_c = r_w_x; op_d = r_q_x; end
            4'd3:  begin op_a = r_q_x; op_b = r_p_x; op_c = r_w_y; op_d = r_q_y; end
            4'd4:  begin op_a = r_w_y; op_b = r_v_y; op_c = r_p_x; op_d = r_w_x; end
            4'd5:  begin op_a = r_w_x; op_b = r_v_x; op_c = r_p_y; op_d = r_w_y; end
            4'd6:  begin op_a = r_w_y; op_b = r_v_y; op_c = r_q_x; op_d = r_w_x; end
            4'd7:  begin op_a = r_w_x; op_b = r_v_x; op_c = r_q_y; op_d = r_w_y; end
            4'd8:  begin op_a = r_v_x; op_b = r_p_x; op_c = r_v_x; op_d = r_q_x; end
            4'd9:  begin op_a = r_v_y; op_b = r_p_y; op_c = r_v_y; op_d = r_q_y; end
            4'd10: begin op_a = r_w_x; op_b = r_p_x; op_c = r_w_x; op_d = r_q_x; end
            4'd11: begin op_a = r_w_y; op_b = r_p_y; op_c = r_w_y; op_d = r_q_y; end
            4'd12: begin op_a = r_p_x; op_b = r_v_x; op_c = r_p_x; op_d = r_w_x; end
            4'd13: begin op_a = r_p_y; op_b = r_v_y; op_c = r_p_y; op_d = r_w_y; end
            4'd14: begin op_a = r_q_x; op_b = r_v_x; op_c = r_q_x; op_d = r_w_x; end
            4'd15: begin op_a = r_q_y; op_b = r_v_y; op_c = r_q_y; op_d = r_w_y; end
            default: begin op_a = r_q_y; op_b = r_p_y; op_c = r_v_x; op_d = r_q_x; end
        endcase
    end

    // Orientation from the stored left side and the arriving right side.
    always_comb begin
        if (r_lhs == u_prod) begin
            orient_new = ORIENT_COLL;
        end else if (r_lhs > u_prod) begin
            orient_new = ORIENT_CW;
        end else begin
            orient_new = ORIENT_CCW;
        end
    end

    // Collect the products of the shared unit as they come out.
    always_ff @(posedge i_clk) begin
        if (u_out_ctl.vld) begin
            if (u_out_ctl.tag < STEP_BOX_FIRST) begin
                if (!u_out_ctl.tag[0]) begin
                    r_lhs <= u_prod;
                end else begin
                    r_orient[u_out_ctl.tag[2:1]] <= orient_new;
                end
            end else begin
                r_box[u_out_ctl.tag[2:0]] <= u_prod[PROD_W-1] | (u_prod == '0);
            end
        end
    end

    // The general crossing case, or an end point collinear and inside the box.
    assign touch = ((r_orient[0] != r_orient[1]) && (r_orient[2] != r_orient[3]))
                || ((r_orient[0] == ORIENT_COLL) && r_box[0] && r_box[1])
                || ((r_orient[1] == ORIENT_COLL) && r_box[2] && r_box[3])
                || ((r_orient[2] == ORIENT_COLL) && r_box[4] && r_box[5])
                || ((r_orient[3] == ORIENT_COLL) && r_box[6] && r_box[7]);

    // Segment end points are captured from the stores' registered read data.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD_I) begin
            r_p_x <= $signed(p_rdata[DATA_W-1:COORD_BITS]);
            r_p_y <= $signed(p_rdata[COORD_BITS-1:0]);
        end
        if (r_state == ST_LOAD_J) begin
            r_q_x <= $signed(p_rdata[DATA_W-1:COORD_BITS]);
            r_q_y <= $signed(p_rdata[COORD_BITS-1:0]);
        end
        if (r_state == ST_LOAD_VA) begin
            r_v_x <= $signed(v_rdata[DATA_W-1:COORD_BITS]);
            r_v_y <= $signed(v_rdata[COORD_BITS-1:0]);
        end
        if (r_state == ST_LOAD_VB) begin
            r_w_x <= $signed(v_rdata[DATA_W-1:COORD_BITS]);
            r_w_y <= $signed(v_rdata[COORD_BITS-1:0]);
        end
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_vt_total <= '0;
            r_pt_total <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_step     <= '0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
            r_out_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_vt_total <= n_vt_total;
            r_pt_total <= n_pt_total;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_step     <= n_step;
            r_count    <= n_count;
            r_out_vld  <= n_out_vld;
            r_out_cnt  <= n_out_cnt;
        end
    end

    // Sequencer: loads, then the walk over pairs i < j and polygon edges k.
    always_comb begin
        n_state    = r_state;
        n_vt_total = r_vt_total;
        n_pt_total = r_pt_total;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_step     = r_step;
        n_count    = r_count;
        n_out_vld  = r_out_vld;
        n_out_cnt  = r_out_cnt;
        v_we       = 1'b0;
        p_we       = 1'b0;
        v_re       = 1'b0;
        p_re       = 1'b0;
        v_raddr    = r_k[VA_W-1:0];
        p_raddr    = r_i[PA_W-1:0];
        u_in_ctl   = '{vld: 1'b0, tag: r_step};

        if (o_out.valid && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_cmd'(i_in.command))
                        CMD_CLEAR: begin
                            n_vt_total = '0;
                            n_pt_total = '0;
                        end
                        CMD_LOAD_VERTEX: begin
                            if (r_vt_total < VT_CW'(MAX_VERTICES)) begin
                                v_we       = 1'b1;
                                n_vt_total = r_vt_total + VT_CW'(1);
                            end
                        end
                        CMD_LOAD_POINT: begin
                            if (r_pt_total < PT_CW'(MAX_POINTS)) begin
                                p_we       = 1'b1;
                                n_pt_total = r_pt_total + PT_CW'(1);
                            end
                        end
                        CMD_COMPUTE: begin
                            n_i     = '0;
                            n_count = '0;
                            n_state = ST_NEXT_I;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NEXT_I: begin
                if ((r_i + PT_CW'(1)) < r_pt_total) begin
                    p_re    = 1'b1;
                    p_raddr = r_i[PA_W-1:0];
                    n_state = ST_LOAD_I;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LOAD_I: begin
                n_j     = r_i + PT_CW'(1);
                n_state = ST_NEXT_J;
            end
            ST_NEXT_J: begin
                if (r_j < r_pt_total) begin
                    p_re    = 1'b1;
                    p_raddr = r_j[PA_W-1:0];
                    n_state = ST_LOAD_J;
                end else begin
                    n_i     = r_i + PT_CW'(1);
                    n_state = ST_NEXT_I;
                end
            end
            ST_LOAD_J: begin
                n_k     = '0;
                // With no polygon every pair is clear.
                n_state = (r_vt_total == '0) ? ST_COUNT : ST_EDGE;
            end
            ST_EDGE: begin
                v_re    = 1'b1;
                v_raddr = r_k[VA_W-1:0];
                n_state = ST_LOAD_VA;
            end
            ST_LOAD_VA: begin
                v_re    = 1'b1;
                v_raddr = k_next_edge[VA_W-1:0];
                n_state = ST_LOAD_VB;
            end
            ST_LOAD_VB: begin
                n_step  = '0;
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                u_in_ctl = '{vld: 1'b1, tag: r_step};
                n_step   = r_step + t_step'(1);
                if (r_step == STEP_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!u_busy) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (touch) begin
                    n_j     = r_j + PT_CW'(1);
                    n_state = ST_NEXT_J;
                end else if (k_inc == r_vt_total) begin
                    n_state = ST_COUNT;
                end else begin
                    n_k     = k_inc;
                    n_state = ST_EDGE;
                end
            end
            ST_COUNT: begin
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + COUNT_W'(1);
                end
                n_j     = r_j + PT_CW'(1);
                n_state = ST_NEXT_J;
            end
            ST_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out_cnt = r_count;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The stores never count past their capacity.
    `PCPC_ASSERT_NOW(a_totals_bounded, i_clk, i_rst_n, 1'b1, (r_pt_total <= PT_CW'(MAX_POINTS)) && (r_vt_total <= VT_CW'(MAX_VERTICES)), "store total beyond capacity")

    // A segment test runs only on a valid pair i < j and an existing edge.
    `PCPC_ASSERT_NOW(a_pair_in_range, i_clk, i_rst_n, r_state == ST_ISSUE, (r_j > r_i) && (r_j < r_pt_total) && (r_k < r_vt_total), "segment test on an invalid pair or edge")

    // Products leave the shared unit only while a test is running.
    `PCPC_ASSERT_NOW(a_prod_in_test, i_clk, i_rst_n, u_out_ctl.vld, (r_state == ST_ISSUE) || (r_state == ST_DRAIN), "product outside a segment test")

    // A finished count always reaches the output register.
    `PCPC_ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, (r_state == ST_DONE) && (!r_out_vld || o_out.ready), r_out_vld && (r_state == ST_IDLE), "finished count not presented")

endmodule

### tb/tb_polygon_clear_pair_counter_unit.sv
// Self-checking testbench for the polygon clear pair counter: directed and random items.
module tb_polygon_clear_pair_counter_unit;
    import pcpc_pkg::*;

    localparam int COORD_W = DEF_COORD_BITS;
    localparam int CMIN = -(1 << (COORD_W - 1));
    localparam int CMAX = (1 << (COORD_W - 1)) - 1;
    localparam int RANDOM_ITEMS = 750;
    localparam int LONG_HOLD = 6000;
    localparam int SETTLE_CYCLES = 60;
    localparam longint CYCLE_LIMIT = 5_000_000;

    // One command item as offered to the block.
    typedef struct {
        t_cmd                      cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        bit                        drain_first;
    } t_item;

    // A point at full precision for the geometry.
    typedef struct {
        longint x;
        longint y;
    } t_xy;

    logic i_clk;
    logic i_rst_n;

    pcpc_in_if #(.COORD_BITS(COORD_W)) cmd_bus ();
    pcpc_out_if count_bus ();

    polygon_clear_pair_counter_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus),
        .o_out   (count_bus)
    );

    // Stimulus waiting to be offered, and counts that the block owes us.
    t_item              pending_items[$];
    logic [COUNT_W-1:0] expected_counts[$];

    // Predicted contents of the polygon and point stores.
    t_xy         polygon[DEF_MAX_VERTICES];
    t_xy         field_pts[DEF_MAX_POINTS];
    int unsigned polygon_n = 0;
    int unsigned field_n = 0;

    t_item              on_wire;
    int unsigned        send_wait;
    int unsigned        send_quiet = 0;
    int unsigned        accepted_total = 0;
    int unsigned        stimulus_total = 0;
    int unsigned        recv_wait;
    int unsigned        recv_quiet = 0;
    int unsigned        hold_now;
    int unsigned        results_seen = 0;
    bit                 long_hold_done = 1'b0;
    int unsigned        mismatches = 0;
    logic [COUNT_W-1:0] want;
    longint             cycle_count = 0;

    // Gap length for either side: mostly none or short, now and then long,
    // with occasional quiet stretches of back-to-back traffic.
    function automatic int unsigned gap_len(inout int unsigned quiet_left);
        int unsigned roll;
        if (quiet_left != 0) begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Coordinate drawn from a range that depends on the sequence scale.
    function automatic int pick_coord(int unsigned scale);
        case (scale)
            0: return int'($urandom_range(0, 8)) - 4;
            1: return int'($urandom_range(0, 80)) - 40;
            2: return int'($urandom());
            default: begin
                case ($urandom_range(0, 5))
                    0: return CMIN;
                    1: return CMAX;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return int'($urandom());
                endcase
            end
        endcase
    endfunction

    function automatic void add_item(t_cmd cmd, int x, int y, bit drain_first);
        t_item it;
        it.cmd = cmd;
        it.x = x[COORD_W-1:0];
        it.y = y[COORD_W-1:0];
        it.drain_first = drain_first;
        pending_items.insert(pending_items.size(), it);
        stimulus_total++;
    endfunction

    // Orientation of the ordered triple a, b, c.
    function automatic t_orient turn_of(t_xy a, t_xy b, t_xy c);
        longint lhs;
        longint rhs;
        lhs = (b.y - a.y) * (c.x - b.x);
        rhs = (b.x - a.x) * (c.y - b.y);
        if (lhs == rhs)
            return ORIENT_COLL;
        return (lhs > rhs) ? ORIENT_CW : ORIENT_CCW;
    endfunction

    // True when q lies in the box spanned by a and c.
    function automatic bit in_span(t_xy a, t_xy q, t_xy c);
        return q.x <= ((a.x > c.x) ? a.x : c.x) && q.x >= ((a.x < c.x) ? a.x : c.x) &&
               q.y <= ((a.y > c.y) ? a.y : c.y) && q.y >= ((a.y < c.y) ? a.y : c.y);
    endfunction

    // Segment p1-q1 against segment p2-q2: general crossing or a collinear touch.
    function automatic bit segments_touch(t_xy p1, t_xy q1, t_xy p2, t_xy q2);
        t_orient o1, o2, o3, o4;
        o1 = turn_of(p1, q1, p2);
        o2 = turn_of(p1, q1, q2);
        o3 = turn_of(p2, q2, p1);
        o4 = turn_of(p2, q2, q1);
        if (o1 != o2 && o3 != o4)
            return 1'b1;
        if (o1 == ORIENT_COLL && in_span(p1, p2, q1))
            return 1'b1;
        if (o2 == ORIENT_COLL && in_span(p1, q2, q1))
            return 1'b1;
        if (o3 == ORIENT_COLL && in_span(p2, p1, q2))
            return 1'b1;
        if (o4 == ORIENT_COLL && in_span(p2, q1, q2))
            return 1'b1;
        return 1'b0;
    endfunction

    // Number of point pairs whose segment misses every polygon edge.
    function automatic logic [COUNT_W-1:0] clear_pair_count();
        int unsigned total;
        int unsigned nk;
        bit          hit;
        total = 0;
        for (int unsigned i = 0; i < field_n; i++) begin
            for (int unsigned j = i + 1; j < field_n; j++) begin
                hit = 1'b0;
                for (int unsigned k = 0; k < polygon_n && !hit; k++) begin
                    nk = (k + 1 < polygon_n) ? k + 1 : 0;
                    hit = segments_touch(field_pts[i], field_pts[j], polygon[k], polygon[nk]);
                end
                if (!hit && total < COUNT_MAX)
                    total++;
            end
        end
        return total[COUNT_W-1:0];
    endfunction

    // Update the predicted stores for one accepted item and note any count owed.
    function automatic void apply_item(t_item it);
        t_xy p;
        p.x = longint'(it.x);
        p.y = longint'(it.y);
        case (it.cmd)
            CMD_CLEAR: begin
                polygon_n = 0;
                field_n = 0;
            end
            CMD_LOAD_VERTEX: begin
                if (polygon_n < DEF_MAX_VERTICES) begin
                    polygon[polygon_n] = p;
                    polygon_n++;
                end
            end
            CMD_LOAD_POINT: begin
                if (field_n < DEF_MAX_POINTS) begin
                    field_pts[field_n] = p;
                    field_n++;
                end
            end
            default: expected_counts.insert(expected_counts.size(), clear_pair_count());
        endcase
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Command driver: holds an offered item until taken, then idles for a
    // random gap; an item marked for draining waits until no count is owed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.command <= CMD_CLEAR;
            cmd_bus.coord_x <= '0;
            cmd_bus.coord_y <= '0;
            send_wait <= 0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                apply_item(on_wire);
                accepted_total <= accepted_total + 1;
            end
            if (cmd_bus.valid && !cmd_bus.ready) begin
                // The offered item stays on the bus.
            end else if (send_wait != 0) begin
                cmd_bus.valid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain_first && expected_counts.size() != 0)) begin
                on_wire = pending_items.pop_front();
                cmd_bus.valid <= 1'b1;
                cmd_bus.command <= on_wire.cmd;
                cmd_bus.coord_x <= on_wire.x;
                cmd_bus.coord_y <= on_wire.y;
                send_wait <= gap_len(send_quiet);
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // Count monitor: checks each taken result against the oldest prediction
    // and stalls the output at random, once for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_bus.ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            hold_now = recv_wait;
            if (count_bus.valid && count_bus.ready) begin
                results_seen++;
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected pair_count, expected none, got %0d",
                             $time, count_bus.pair_count);
                    mismatches++;
                end else begin
                    want = expected_counts.pop_front();
                    if (count_bus.pair_count !== want) begin
                        $display("%0t: pair_count mismatch, expected %0d, got %0d",
                                 $time, want, count_bus.pair_count);
                        mismatches++;
                    end
                end
                hold_now = gap_len(recv_quiet);
            end
            if (!long_hold_done && results_seen >= 12) begin
                hold_now = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (hold_now == 0 && $urandom_range(0, 15) == 0) begin
                hold_now = gap_len(recv_quiet);
            end
            if (hold_now != 0) begin
                count_bus.ready <= 1'b0;
                recv_wait <= hold_now - 1;
            end else begin
                count_bus.ready <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned vtx_since, pt_since, nv, np, scale, burst, made;
        t_cmd        kind;

        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_CLEAR;
        cmd_bus.coord_x = '0;
        cmd_bus.coord_y = '0;
        count_bus.ready = 1'b0;
        i_rst_n = 1'b0;

        // Empty stores, then a pair with no polygon at all.
        add_item(CMD_CLEAR, CMIN, CMAX, 1'b0);
        add_item(CMD_COMPUTE, CMAX, CMIN, 1'b0);
        add_item(CMD_LOAD_POINT, 0, 0, 1'b0);
        add_item(CMD_LOAD_POINT, 10, 0, 1'b0);
        add_item(CMD_COMPUTE, 0, 0, 1'b0);
        // A single vertex gives a degenerate edge lying on the segment.
        add_item(CMD_LOAD_VERTEX, 5, 0, 1'b0);
        add_item(CMD_COMPUTE, 0, 0, 1'b0);
        // Collinear overlaps, a shared end point, identical points and extremes.
        add_item(CMD_CLEAR, 0, 0, 1'b0);
        add_item(CMD_LOAD_VERTEX, 10, 0, 1'b0);
        add_item(CMD_LOAD_VERTEX, 20, 0, 1'b0);
        add_item(CMD_LOAD_VERTEX, 15, 10, 1'b0);
        add_item(CMD_LOAD_POINT, 0, 0, 1'b0);
        add_item(CMD_LOAD_POINT, 10, 0, 1'b0);
        add_item(CMD_LOAD_POINT, 12, 0, 1'b0);
        add_item(CMD_LOAD_POINT, 0, 0, 1'b0);
        add_item(CMD_LOAD_POINT, CMIN, CMAX, 1'b0);
        add_item(CMD_LOAD_POINT, CMAX, CMIN, 1'b0);
        add_item(CMD_COMPUTE, CMIN, CMIN, 1'b0);
        // A square at the corners of the coordinate range.
        add_item(CMD_CLEAR, CMAX, CMAX, 1'b0);
        add_item(CMD_LOAD_VERTEX, CMIN, CMIN, 1'b0);
        add_item(CMD_LOAD_VERTEX, CMAX, CMIN, 1'b0);
        add_item(CMD_LOAD_VERTEX, CMAX, CMAX, 1'b0);
        add_item(CMD_LOAD_VERTEX, CMIN, CMAX, 1'b0);
        add_item(CMD_LOAD_POINT, 0, 0, 1'b0);
        add_item(CMD_LOAD_POINT, 1, 1, 1'b0);
        add_item(CMD_LOAD_POINT, CMIN, 0, 1'b0);
        add_item(CMD_COMPUTE, 0, 0, 1'b0);

        // Point store overfilled with no polygon: the largest count.
        add_item(CMD_CLEAR, 0, 0, 1'b1);
        for (int i = 0; i < DEF_MAX_POINTS + 2; i++)
            add_item(CMD_LOAD_POINT, pick_coord(2), pick_coord(2), 1'b0);
        add_item(CMD_COMPUTE, 0, 0, 1'b0);
        // Vertex store overfilled; the dropped vertex would close the polygon
        // across the only pair.
        add_item(CMD_CLEAR, 0, 0, 1'b0);
        for (int i = 0; i < DEF_MAX_VERTICES; i++)
            add_item(CMD_LOAD_VERTEX, 1000 + i, 1000, 1'b0);
        add_item(CMD_LOAD_VERTEX, -1000, -1000, 1'b0);
        add_item(CMD_LOAD_POINT, 0, -10, 1'b0);
        add_item(CMD_LOAD_POINT, 0, 10, 1'b0);
        add_item(CMD_COMPUTE, 0, 0, 1'b0);

        // Random part: mostly complete polygon/point/compute sequences, the
        // rest loose items with the stores kept small to bound compute time.
        vtx_since = DEF_MAX_VERTICES;
        pt_since = 2;
        made = 0;
        while (made < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: scale = 0;
                4, 5, 6:    scale = 1;
                7, 8:       scale = 2;
                default:    scale = 3;
            endcase
            if ($urandom_range(0, 9) < 8) begin
                nv = $urandom_range(0, 6);
                np = $urandom_range(0, 7);
                add_item(CMD_CLEAR, pick_coord(scale), pick_coord(scale),
                         made == 0 || $urandom_range(0, 39) == 0);
                made++;
                while (nv + np != 0) begin
                    if (np == 0 || (nv != 0 && $urandom_range(0, 1) == 0)) begin
                        add_item(CMD_LOAD_VERTEX, pick_coord(scale), pick_coord(scale), 1'b0);
                        nv--;
                    end else begin
                        add_item(CMD_LOAD_POINT, pick_coord(scale), pick_coord(scale), 1'b0);
                        np--;
                    end
                    made++;
                end
                add_item(CMD_COMPUTE, pick_coord(scale), pick_coord(scale), 1'b0);
                made++;
                vtx_since = 0;
                pt_since = 0;
            end else begin
                burst = $urandom_range(1, 6);
                repeat (burst) begin
                    if (vtx_since > 8 || pt_since > 8) begin
                        add_item(CMD_CLEAR, pick_coord(scale), pick_coord(scale), 1'b0);
                        made++;
                        vtx_since = 0;
                        pt_since = 0;
                    end
                    kind = t_cmd'($urandom_range(0, 3));
                    add_item(kind, pick_coord(scale), pick_coord(scale), 1'b0);
                    made++;
                    case (kind)
                        CMD_CLEAR: begin
                            vtx_since = 0;
                            pt_since = 0;
                        end
                        CMD_LOAD_VERTEX: vtx_since++;
                        CMD_LOAD_POINT:  pt_since++;
                        default: ;
                    endcase
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_total != stimulus_total)
            @(posedge i_clk);
        while (expected_counts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
